@@ hdl/jsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsr_pkg: shared types and constants for the jet select and rank core
// Register indexes, reset values, controller command/status structs.
// ----------------------------------------------------------------------------
package jsr_pkg;

	localparam int MAX_JETS_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 16;
	localparam int NUM_LISTS     = 4;
	localparam int RESULT_LIMIT  = 64;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PT_THR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ETA_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAG_THR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TAG  = 2'd3;

	localparam logic [15:0] PT_THR_RST  = 16'd160;
	localparam logic [10:0] ETA_THR_RST = 11'd640;
	localparam logic [15:0] TAG_THR_RST = 16'd614;
	localparam logic [4:0]  MIN_TAG_RST = 5'd3;

	typedef enum logic [1:0] {
		ST_COLLECT = 2'b01,
		ST_EMIT    = 2'b10
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic insert;   // insert accepted jet
		logic clear;    // clear event state
		logic advance;  // step emit pointer
		logic emit_rst; // reset emit pointer
	} jsr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic at_end;    // current pointer is final emitted entry
	} jsr_sts_t;

endpackage

@@ hdl/jsr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsr_ctrl: event controller
// Collects jets, then walks the stored lists onto the output stream.
// ----------------------------------------------------------------------------
module jsr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_present,
	input  logic               in_last,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	input  jsr_pkg::jsr_sts_t  sts,
	output jsr_pkg::jsr_cmd_t  cmd
);
	import jsr_pkg::*;

	state_t state_q;
	logic   hold_q;    // output beat pending
	logic   acc;
	logic   ends;
	logic   take;

	assign in_ready  = (state_q == ST_COLLECT);
	assign acc       = in_valid && in_ready;
	assign ends      = !in_present || in_last;
	assign out_valid = hold_q;
	assign take      = hold_q && out_ready;

	always_comb begin
		cmd.insert   = acc && in_present;
		cmd.emit_rst = acc && ends;
		cmd.advance  = take && !sts.at_end;
		cmd.clear    = take && sts.at_end;
	end

	// sequence collect / emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			hold_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (acc && ends) begin
						state_q <= ST_EMIT;
						hold_q  <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (take && sts.at_end) begin
						state_q <= ST_COLLECT;
						hold_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
					hold_q  <= 1'b0;
				end
			endcase
		end
	end

	a_no_accept_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !in_ready) else $error("input taken while emitting");
	a_valid_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT) else $error("output outside emit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("beat dropped");

endmodule

@@ hdl/jsr_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsr_dp: sorting cell chains and emit pointer
// Four chains of sorting cells insert one jet per cycle while collecting; a pointer walks them.
// ----------------------------------------------------------------------------
module jsr_dp #(
	parameter int MAX_JETS  = jsr_pkg::MAX_JETS_DEF,
	parameter int KEY_WIDTH = jsr_pkg::KEY_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  jsr_pkg::jsr_cmd_t  cmd,
	output jsr_pkg::jsr_sts_t  sts,
	input  logic [15:0]        pt_thr,
	input  logic [10:0]        eta_thr,
	input  logic signed [15:0] tag_thr,
	input  logic [4:0]         min_tag,
	input  logic [15:0]        pt,
	input  logic signed [11:0] eta,
	input  logic signed [15:0] csv,
	input  logic signed [15:0] cmva,
	output logic [1:0]         list_id,
	output logic [3:0]         rank,
	output logic [3:0]         jet_index,
	output logic               entry_valid,
	output logic [4:0]         tagged_count,
	output logic               event_pass,
	output logic               overflow
);
	import jsr_pkg::*;

	localparam int IW = $clog2(MAX_JETS);
	localparam int PW = $clog2(MAX_JETS + 1);
	localparam int LS = 1 << IW;
	localparam int NE = NUM_LISTS * LS;
	localparam int EW = $clog2(NE);
	localparam int NR = NUM_LISTS * MAX_JETS;
	localparam int CW = $clog2(NR + 1);
	localparam int RL = (NR < RESULT_LIMIT) ? NR : RESULT_LIMIT;

	logic [KEY_WIDTH-1:0] key_q   [NUM_LISTS][MAX_JETS];
	logic [IW-1:0]        jet_q   [NUM_LISTS][MAX_JETS];
	logic [MAX_JETS-1:0]  valid_q [NUM_LISTS];
	logic [PW-1:0]        pos_q;
	logic [4:0]           tcnt_q;
	logic                 ovf_q;
	logic [EW-1:0]        ptr_q;
	logic [CW-1:0]        sent_q;

	// jet qualification
	logic [11:0]          aeta;
	logic                 room, central, is_btag;
	logic [NUM_LISTS-1:0] ins;
	logic [KEY_WIDTH-1:0] key [NUM_LISTS];

	function automatic logic [KEY_WIDTH-1:0] sat16(input logic [15:0] v);
		logic [31:0] w;
		logic [31:0] mx;
		w  = {16'd0, v};
		mx = (32'd1 << KEY_WIDTH) - 32'd1;
		sat16 = (w > mx) ? mx[KEY_WIDTH-1:0] : w[KEY_WIDTH-1:0];
	endfunction

	assign aeta    = eta[11] ? 12'(-eta) : 12'(eta);
	assign room    = pos_q < PW'(MAX_JETS);
	assign central = aeta < {1'b0, eta_thr};
	assign is_btag = central && (pt > pt_thr) && (csv > tag_thr);
	assign ins[0]  = cmd.insert && room && central;
	assign ins[1]  = cmd.insert && room && is_btag;
	assign ins[2]  = ins[1] && (csv > 16'sd0);
	assign ins[3]  = ins[1] && (cmva > 16'sd0);
	assign key[0]  = sat16(pt);
	assign key[1]  = sat16(pt);
	assign key[2]  = sat16(csv);
	assign key[3]  = sat16(cmva);

	// sorting cell chains: each cell decides from its own and its neighbor, plus a chain-wide equal-key hit
	genvar l, c;
	generate
		for (l = 0; l < NUM_LISTS; l++) begin : g_list
			logic [MAX_JETS-1:0] ge;   // cell key strictly above new key
			logic [MAX_JETS-1:0] eq;
			for (c = 0; c < MAX_JETS; c++) begin : g_cell
				assign ge[c] = valid_q[l][c] && (key_q[l][c] > key[l]);
				assign eq[c] = valid_q[l][c] && (key_q[l][c] == key[l]);
			end
			logic hit;
			assign hit = |(eq & ~ge);
			for (c = 0; c < MAX_JETS; c++) begin : g_upd
				logic                 prev_ge;
				logic                 prev_v;
				logic [KEY_WIDTH-1:0] prev_key;
				logic [IW-1:0]        prev_jet;
				if (c == 0) begin : g_f
					assign prev_ge  = 1'b1;
					assign prev_v   = 1'b0;
					assign prev_key = '0;
					assign prev_jet = '0;
				end else begin : g_n
					assign prev_ge  = ge[c-1];
					assign prev_v   = valid_q[l][c-1];
					assign prev_key = key_q[l][c-1];
					assign prev_jet = jet_q[l][c-1];
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						valid_q[l][c] <= 1'b0;
					end else if (cmd.clear) begin
						valid_q[l][c] <= 1'b0;
					end else if (ins[l] && !ge[c]) begin
						if (hit) begin
							// equal key replaces index only
						end else if (!prev_ge) begin
							valid_q[l][c] <= prev_v;
						end else begin
							valid_q[l][c] <= 1'b1;
						end
					end
				end
				always_ff @(posedge clk) begin
					if (ins[l] && !ge[c]) begin
						if (hit) begin
							if (eq[c]) jet_q[l][c] <= pos_q[IW-1:0];
						end else if (!prev_ge) begin
							key_q[l][c] <= prev_key;
							jet_q[l][c] <= prev_jet;
						end else begin
							key_q[l][c] <= key[l];
							jet_q[l][c] <= pos_q[IW-1:0];
						end
					end
				end
			end
		end
	endgenerate

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tcnt_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.clear) begin
			pos_q  <= '0;
			tcnt_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.insert) begin
			if (!room) begin
				ovf_q <= 1'b1;
			end else begin
				pos_q <= pos_q + PW'(1);
				if (is_btag && tcnt_q != 5'd31) tcnt_q <= tcnt_q + 5'd1;
			end
		end
	end

	// emit pointer: list in the upper bits, rank in the lower bits
	logic [NE-1:0] vflat;
	logic [EW-1:0] first_v, next_v, cur;
	logic          has_next;
	always_comb begin
		vflat = '0;
		for (int i = 0; i < NUM_LISTS; i++)
			for (int j = 0; j < MAX_JETS; j++)
				vflat[i * LS + j] = valid_q[i][j];
	end
	always_comb begin
		first_v = '0;
		for (int i = NE - 1; i >= 0; i--) begin
			if (vflat[i]) first_v = EW'(i);
		end
	end

	// pointer starts at the first valid entry
	assign cur = (sent_q == '0) ? first_v : ptr_q;

	// find next valid entry after the current one
	always_comb begin
		next_v   = '0;
		has_next = 1'b0;
		for (int i = NE - 1; i >= 0; i--) begin
			if (vflat[i] && i > int'(cur)) begin
				next_v   = EW'(i);
				has_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			sent_q <= '0;
		end else if (cmd.emit_rst) begin
			ptr_q  <= '0;
			sent_q <= '0;
		end else if (cmd.advance) begin
			ptr_q  <= next_v;
			sent_q <= sent_q + CW'(1);
		end
	end

	assign sts.at_end    = !(|vflat) || (sent_q == CW'(RL - 1)) || !has_next;

	assign entry_valid  = |vflat;
	assign list_id      = entry_valid ? 2'(cur[EW-1:IW]) : 2'd0;
	assign rank         = entry_valid ? 4'(cur[IW-1:0]) : 4'd0;
	assign jet_index    = entry_valid ? 4'(jet_q[cur[EW-1:IW]][cur[IW-1:0]]) : 4'd0;
	assign tagged_count = tcnt_q;
	assign event_pass   = tcnt_q >= min_tag;
	assign overflow     = ovf_q;

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> pos_q == PW'(MAX_JETS)) else $error("overflow before full");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> pos_q == '0 && tcnt_q == '0) else $error("clear missed");
	a_sub: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[1] != '0) |-> (valid_q[0] != '0)) else $error("tagged without central");

endmodule

@@ hdl/jet_select_and_rank_core.sv @@
`timescale 1ns / 1ps
// Latency: a result stream starts the cycle after the event's final item is taken.
// Throughput: one jet per cycle while collecting; then one result beat per cycle while the
// output is ready, one beat per stored entry (at least one), while no input is taken.
// Insertion is a single pass through each chain of sorting cells.
// Reset: arst_n clears lists, counters and flags; registers return to defaults.
// ----------------------------------------------------------------------------
// jet_select_and_rank_core: jet selection and ranking, top level
// Config registers, controller and sorting datapath.
// ----------------------------------------------------------------------------
module jet_select_and_rank_core #(
	parameter int MAX_JETS  = jsr_pkg::MAX_JETS_DEF,
	parameter int KEY_WIDTH = jsr_pkg::KEY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [jsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jsr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: pt[15:0], eta[27:16], csv_tag[43:28], cmva_tag[59:44], zeros
	input  logic [63:0]                   s_axis_tdata,
	input  logic                          s_axis_tuser,  // jet_present
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: rank[3:0], jet_index[7:4], entry_valid[8], tagged_count[13:9],
	// event_pass[14], overflow[15]
	output logic [15:0]                   m_axis_tdata,
	output logic [1:0]                    m_axis_tuser,  // list_id
	output logic                          m_axis_tlast
);
	import jsr_pkg::*;

	logic [15:0] pt_thr_q;
	logic [10:0] eta_thr_q;
	logic [15:0] tag_thr_q;
	logic [4:0]  min_tag_q;
	jsr_cmd_t    cmd;
	jsr_sts_t    sts;
	logic [3:0]  rank, jidx;
	logic        ev, pass, ovf;
	logic [4:0]  tcnt;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_thr_q  <= PT_THR_RST;
			eta_thr_q <= ETA_THR_RST;
			tag_thr_q <= TAG_THR_RST;
			min_tag_q <= MIN_TAG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PT_THR:  pt_thr_q  <= cfg_data;
				REG_ETA_THR: eta_thr_q <= cfg_data[10:0];
				REG_TAG_THR: tag_thr_q <= cfg_data;
				REG_MIN_TAG: min_tag_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	jsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_present(s_axis_tuser),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	jsr_dp #(.MAX_JETS(MAX_JETS), .KEY_WIDTH(KEY_WIDTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pt_thr      (pt_thr_q),
		.eta_thr     (eta_thr_q),
		.tag_thr     (tag_thr_q),
		.min_tag     (min_tag_q),
		.pt          (s_axis_tdata[15:0]),
		.eta         (s_axis_tdata[27:16]),
		.csv         (s_axis_tdata[43:28]),
		.cmva        (s_axis_tdata[59:44]),
		.list_id     (m_axis_tuser),
		.rank        (rank),
		.jet_index   (jidx),
		.entry_valid (ev),
		.tagged_count(tcnt),
		.event_pass  (pass),
		.overflow    (ovf)
	);

	assign m_axis_tdata = {ovf, pass, tcnt, ev, jidx, rank};
	assign m_axis_tlast = sts.at_end;

endmodule

@@ tb/jet_select_and_rank_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_select_and_rank_core_tb: self-checking bench for the jet ranking core
// Streams jet events through the core, predicts the four ranked lists and the
// event flags for every event end, and compares each result beat in order.
// ----------------------------------------------------------------------------
module jet_select_and_rank_core_tb;
	import jsr_pkg::*;

	localparam int NJ = MAX_JETS_DEF;
	localparam int CYCLE_LIMIT = 400000;

	// one result beat
	typedef struct packed {
		logic [1:0] list_id;
		logic [3:0] rank;
		logic [3:0] jet_index;
		logic       entry_valid;
		logic [4:0] tagged_count;
		logic       event_pass;
		logic       overflow;
		logic       last;
	} rank_beat_t;

	// one jet beat
	typedef struct packed {
		logic               present;
		logic [15:0]        pt;
		logic signed [11:0] eta;
		logic signed [15:0] csv;
		logic signed [15:0] cmva;
		logic               last_jet;
	} jet_t;

	// directed row: jet plus optional typed-in expectation of the first beat
	typedef struct packed {
		jet_t       jet;
		logic       has_exp;
		rank_beat_t exp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	jet_select_and_rank_core dut (.*);

	always #10 clk = ~clk;

	// predictor copy of registers and event state
	logic [15:0]        pt_thr;
	logic [10:0]        eta_thr;
	logic signed [15:0] tag_thr;
	logic [4:0]         min_tag;
	logic [15:0] list_key [4][NJ];
	logic [3:0]  list_jet [4][NJ];
	logic        list_ok  [4][NJ];
	int unsigned jet_pos, tag_cnt;
	logic        ovf;

	rank_beat_t expected_beats[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	int pct_idle = 34;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic clear_event();
		for (int l = 0; l < 4; l++)
			for (int r = 0; r < NJ; r++) begin
				list_key[l][r] = '0;
				list_jet[l][r] = '0;
				list_ok[l][r] = 1'b0;
			end
		jet_pos = 0;
		tag_cnt = 0;
		ovf = 1'b0;
	endtask

	// append one predicted beat
	task automatic queue_beat(input rank_beat_t b);
		expected_beats = {expected_beats, b};
	endtask

	// sorted insert; equal key takes the new jet index
	task automatic place(input int l, input logic [15:0] key, input logic [3:0] j);
		int p;
		p = 0;
		while (p < NJ && list_ok[l][p] && list_key[l][p] > key)
			p++;
		if (p >= NJ)
			return;
		if (list_ok[l][p] && list_key[l][p] == key) begin
			list_jet[l][p] = j;
			return;
		end
		for (int q = NJ - 1; q > p; q--) begin
			list_key[l][q] = list_key[l][q-1];
			list_jet[l][q] = list_jet[l][q-1];
			list_ok[l][q] = list_ok[l][q-1];
		end
		list_key[l][p] = key;
		list_jet[l][p] = j;
		list_ok[l][p] = 1'b1;
	endtask

	task automatic rank_event(input jet_t jt);
		int aeta;
		int n;
		rank_beat_t b;
		if (jt.present) begin
			if (jet_pos >= NJ)
				ovf = 1'b1;
			else begin
				aeta = (jt.eta < 0) ? -int'(jt.eta) : int'(jt.eta);
				if (aeta < int'(eta_thr)) begin
					place(0, jt.pt, jet_pos[3:0]);
					if (jt.pt > pt_thr && jt.csv > tag_thr) begin
						if (tag_cnt < 31)
							tag_cnt++;
						place(1, jt.pt, jet_pos[3:0]);
						if (jt.csv > 0)
							place(2, jt.csv, jet_pos[3:0]);
						if (jt.cmva > 0)
							place(3, jt.cmva, jet_pos[3:0]);
					end
				end
				jet_pos++;
			end
		end
		if (jt.present && !jt.last_jet)
			return;
		n = 0;
		b.tagged_count = tag_cnt[4:0];
		b.event_pass = (tag_cnt >= min_tag);
		b.overflow = ovf;
		b.last = 1'b0;
		for (int l = 0; l < 4; l++)
			for (int r = 0; r < NJ; r++)
				if (list_ok[l][r] && n < RESULT_LIMIT) begin
					b.list_id = l[1:0];
					b.rank = r[3:0];
					b.jet_index = list_jet[l][r];
					b.entry_valid = 1'b1;
					queue_beat(b);
					n++;
				end
		if (n == 0) begin
			b.list_id = '0;
			b.rank = '0;
			b.jet_index = '0;
			b.entry_valid = 1'b0;
			queue_beat(b);
		end
		expected_beats[$].last = 1'b1;
		clear_event();
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PT_THR:  pt_thr = val;
			REG_ETA_THR: eta_thr = val[10:0];
			REG_TAG_THR: tag_thr = val;
			REG_MIN_TAG: min_tag = val[4:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drive one jet beat, with random idle cycles in front
	task automatic send_jet(input jet_t jt);
		while (!calm && $urandom_range(99) < pct_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'h0, jt.cmva, jt.csv, jt.eta, jt.pt};
		s_axis_tuser <= jt.present;
		s_axis_tlast <= jt.last_jet;
		do @(posedge clk); while (!s_axis_tready);
		rank_event(jt);
	endtask

	// drop valid and wait for every predicted beat
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic jet_t rand_jet(input bit fin);
		jet_t jt;
		jt.present = ($urandom_range(19) != 0);
		case ($urandom_range(3))
			0: jt.pt = 16'($urandom);
			1: jt.pt = 16'($urandom_range(400));
			default: jt.pt = 16'd100 + 16'($urandom_range(7)) * 16'd40;
		endcase
		jt.eta = ($urandom_range(3) == 0) ? 12'($urandom) : 12'(int'($urandom_range(1400)) - 700);
		jt.csv = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(1024)) - 100);
		jt.cmva = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(8)) * 16'd100;
		jt.last_jet = fin;
		return jt;
	endfunction

	// output side: random stall and in-order compare
	always @(posedge clk) begin
		rank_beat_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tdata[8],
					m_axis_tdata[13:9], m_axis_tdata[14], m_axis_tdata[15], m_axis_tlast};
				if (expected_beats.size() == 0)
					report("unexpected beat", got, 0);
				else begin
					want = expected_beats.pop_front();
					if (got.list_id != want.list_id) report("list_id", got.list_id, want.list_id);
					if (got.rank != want.rank) report("rank", got.rank, want.rank);
					if (got.jet_index != want.jet_index)
						report("jet_index", got.jet_index, want.jet_index);
					if (got.entry_valid != want.entry_valid)
						report("entry_valid", got.entry_valid, want.entry_valid);
					if (got.tagged_count != want.tagged_count)
						report("tagged_count", got.tagged_count, want.tagged_count);
					if (got.event_pass != want.event_pass)
						report("event_pass", got.event_pass, want.event_pass);
					if (got.overflow != want.overflow)
						report("overflow", got.overflow, want.overflow);
					if (got.last != want.last) report("last", got.last, want.last);
				end
			end
			m_axis_tready <= calm || ($urandom_range(99) >= pct_idle);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("jet_select_and_rank_core_tb NOT OK");
			$finish;
		end
	end

	row_t dir_rows[$];

	function automatic row_t mk(input jet_t jt);
		row_t rw;
		rw.jet = jt;
		rw.has_exp = 1'b0;
		rw.exp = '0;
		return rw;
	endfunction

	initial begin
		row_t rw;
		jet_t jt;
		int nj;
		int base;
		pt_thr = PT_THR_RST;
		eta_thr = ETA_THR_RST;
		tag_thr = TAG_THR_RST;
		min_tag = MIN_TAG_RST;
		clear_event();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: empty event right after reset (typed result)
		rw = mk('{present: 0, pt: 0, eta: 0, csv: 0, cmva: 0, last_jet: 1});
		rw.has_exp = 1'b1;
		rw.exp = '{list_id: 0, rank: 0, jet_index: 0, entry_valid: 0, tagged_count: 0,
			event_pass: 0, overflow: 0, last: 1};
		dir_rows = {dir_rows, rw};
		// extremes: max pt central, forward eta, negative eta edge
		dir_rows = {dir_rows, mk('{1, 16'hFFFF, 12'sd0, 16'sh7FFF, 16'sh7FFF, 1'b0})};
		dir_rows = {dir_rows, mk('{1, 16'd0, -12'sd2048, 16'sh8000, 16'sh8000, 1'b0})};
		dir_rows = {dir_rows, mk('{1, 16'd161, 12'sd639, 16'sd615, 16'sd0, 1'b0})};
		dir_rows = {dir_rows, mk('{1, 16'd161, -12'sd640, 16'sd615, 16'sd5, 1'b0})};
		// repeated max pt out of eta range, and a jet at the pt and tag thresholds
		dir_rows = {dir_rows, mk('{1, 16'hFFFF, 12'sd2047, 16'sh7FFF, 16'sh7FFF, 1'b0})};
		dir_rows = {dir_rows, mk('{1, 16'd160, 12'sd1, 16'sd614, 16'sd1, 1'b0})};
		// absent jet closes the event
		dir_rows = {dir_rows, mk('{0, 16'hAAAA, 12'sh555, 16'h5555, 16'hAAAA, 1'b0})};
		// no-jet item with last set, directly after: empty again
		rw = mk('{0, 16'h5555, 12'shAAA, 16'hAAAA, 16'h5555, 1'b1});
		rw.has_exp = 1'b1;
		rw.exp = '{list_id: 0, rank: 0, jet_index: 0, entry_valid: 0, tagged_count: 0,
			event_pass: 0, overflow: 0, last: 1};
		dir_rows = {dir_rows, rw};
		// single non-central jet with last: empty lists, flag values
		dir_rows = {dir_rows, mk('{1, 16'd1000, 12'sd1000, 16'sd900, 16'sd900, 1'b1})};

		foreach (dir_rows[i]) begin
			if (dir_rows[i].has_exp) begin
				drain();
				send_jet(dir_rows[i].jet);
				if (expected_beats.size() != 1 || expected_beats[0] != dir_rows[i].exp)
					report("directed expectation", expected_beats.size(), 1);
			end else
				send_jet(dir_rows[i].jet);
		end

		// overflow event: 18 tagged central jets with ties
		for (int k = 0; k < 18; k++)
			send_jet('{1, 16'(200 + (k % 9) * 10), 12'sd0, 16'(700 + k), 16'(k - 3),
				1'(k == 17)});
		drain();

		// register settings, extremes included; every register written
		write_reg(REG_PT_THR, 16'd0);
		write_reg(REG_ETA_THR, 16'h7FF);
		write_reg(REG_TAG_THR, 16'h8000);
		write_reg(REG_MIN_TAG, 16'd0);
		for (int k = 0; k < 5; k++)
			send_jet(rand_jet(k == 4));
		drain();
		write_reg(REG_PT_THR, 16'hFFFF);
		write_reg(REG_ETA_THR, 16'd0);
		write_reg(REG_TAG_THR, 16'h7FFF);
		write_reg(REG_MIN_TAG, 16'd16);
		for (int k = 0; k < 4; k++)
			send_jet(rand_jet(k == 3));
		drain();
		write_reg(REG_PT_THR, 16'd160);
		write_reg(REG_ETA_THR, 16'd640);
		write_reg(REG_TAG_THR, 16'd300);
		write_reg(REG_MIN_TAG, 16'd2);

		// random events; a calm stretch in the middle
		base = 0;
		while (base < 95) begin
			if (base >= 35 && base < 65) calm = 1;
			else calm = 0;
			nj = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
			for (int k = 0; k < nj; k++) begin
				jt = rand_jet(k == nj - 1);
				send_jet(jt);
				if (!jt.present)
					break;
			end
			base += nj;
			if ($urandom_range(5) == 0)
				drain();
		end
		calm = 0;
		drain();
		write_reg(REG_MIN_TAG, 16'd31);
		send_jet(rand_jet(1'b1));

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0)
			$display("jet_select_and_rank_core_tb OK");
		else
			$display("jet_select_and_rank_core_tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/jsr_pkg.sv
hdl/jsr_ctrl.sv
hdl/jsr_dp.sv
hdl/jet_select_and_rank_core.sv
tb/jet_select_and_rank_core_tb.sv
